// ===== src/bkd_pkg.sv =====
// shared types and constants for the bell kernel density splat block
// no dependencies; every other file but bkd_ram imports this package
`default_nettype none

package bkd_pkg;

  // request codes of an input item
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SMOOTH = 2'd0;
  localparam logic [1:0] CFG_BIN_W  = 2'd1;
  localparam logic [1:0] CFG_BIN_H  = 2'd2;

  // field widths (lengths are doubled q12.4, i.e. 1/32 units)
  localparam int CRD_W   = 16;           // q12.4 coordinate
  localparam int IDX_W   = 8;            // bin index, covers grids up to 256
  localparam int POS2_W  = CRD_W + 1;    // doubled centre
  localparam int RAD_W   = CRD_W + 2;    // doubled radius w + 2*s
  localparam int RR_W    = 2 * RAD_W;    // squared radius
  localparam int AMP_W   = 18;           // amplitude, q2.16
  localparam int PHI_W   = 17;           // bell value, q0.16 up to 1.0
  localparam int APY_W   = AMP_W + PHI_W;
  localparam int PROD_W  = APY_W + PHI_W;
  localparam int CEN_W   = IDX_W + 1 + CRD_W;
  localparam int DEN_W   = 24;           // density q8.16
  localparam int MEM_W   = DEN_W + 1;    // saturation mark over density
  localparam logic [DEN_W-1:0] DMAX = 24'hFFFFFF;

  // shared divider sizes
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 38;
  localparam int DIV_QB = 18;
  localparam int DIV_CW = 5;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    req_t             req_type;
    logic [1:0]       tier;
    logic [CRD_W-1:0] center_x;
    logic [CRD_W-1:0] center_y;
    logic [CRD_W-1:0] mod_width;
    logic [CRD_W-1:0] mod_height;
    logic [5:0]       read_row;
    logic [5:0]       read_col;
  } in_item_t;

  typedef struct packed {
    logic [DEN_W-1:0] bin_density;
    logic             saturated;
  } out_item_t;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_ADD,
    JOB_READ
  } job_op_t;

  typedef struct packed {
    job_op_t           op;
    logic              ok;      // read tier and bin inside the grid
    logic [1:0]        tier;
    logic [IDX_W-1:0]  r0;      // first row, or row of a read
    logic [IDX_W-1:0]  r1;
    logic [IDX_W-1:0]  c0;      // first column, or column of a read
    logic [IDX_W-1:0]  c1;
    logic [POS2_W-1:0] x2;
    logic [POS2_W-1:0] y2;
    logic [RAD_W-1:0]  rx2;
    logic [RAD_W-1:0]  ry2;
    logic [RR_W-1:0]   rxx;
    logic [RR_W-1:0]   ryy;
    logic [CRD_W-1:0]  bw;
    logic [CRD_W-1:0]  bh;
    logic [AMP_W-1:0]  amp;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SETUP,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    DS_AMP,
    DS_CLO,
    DS_CHI,
    DS_RLO,
    DS_RHI
  } div_step_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CLR,
    B_RQ,
    B_RS,
    B_CX,
    B_DX,
    B_SQ,
    B_DS,
    B_DV,
    B_PM,
    B_RD
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/bkd_ram.sv =====
// generic single write, single read memory with registered read data
// no dependencies
`default_nettype none

module bkd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/bkd_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on bkd_pkg; the quotient must fit in DIV_QB bits
`default_nettype none

module bkd_div import bkd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic                   done,
  output logic      [DIV_QB-1:0] quo
);

  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_QB-1:0] sh_r, sh_nxt;
  logic [DIV_CW-1:0] cnt_r;
  logic              run_r, done_r;
  logic [DIV_DW:0]   trial;
  logic              ge;

  // one compare and subtract step
  always_comb begin
    trial   = {rem_r, sh_r[DIV_QB-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : DIV_DW'(trial);
    sh_nxt  = {sh_r[DIV_QB-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_CW'(DIV_QB);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DIV_DW'(num[DIV_NW-1:DIV_QB]);
      sh_r  <= num[DIV_QB-1:0];
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign done = done_r;
  assign quo  = sh_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !run_r)
    else $error("divider done while still running");

endmodule

`default_nettype wire

// ===== src/bkd_queue.sv =====
// short request queue between the front and the back
// depends on bkd_pkg for job_t
`default_nettype none

module bkd_queue import bkd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  assign full  = cnt_r == CW'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = slot_r[rp_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== src/bkd_front.sv =====
// front end: request intake, configuration registers, per-module setup
// depends on bkd_pkg and bkd_div; hands finished requests to the queue
`default_nettype none

module bkd_front import bkd_pkg::*; #(
  parameter int GRID  = 64,
  parameter int TIERS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  input  wire logic       hold,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [CRD_W-1:0] cfg_data,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_job
);

  front_state_t state_r, state_nxt;
  div_step_t    step_r;
  logic         launched_r;
  in_item_t     item_r;

  logic [CRD_W-1:0]  smooth_r, binw_r, binh_r;
  logic [CRD_W-1:0]  bw_r, bh_r;
  logic [POS2_W-1:0] x2_r, y2_r;
  logic [RAD_W-1:0]  rx2_r, ry2_r;
  logic [31:0]       wh_r;
  logic [RR_W-1:0]   rxy_r, rxx_r, ryy_r;
  logic [DIV_QB-1:0] amp_r, clo_r, chi_r, rlo_r, rhi_r;

  logic [CRD_W-1:0]  bw_c, bh_c, sx_c, sy_c;
  logic              tier_ok, keep, accept;
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_QB-1:0] div_quo;
  logic [IDX_W-1:0]  chi_clip, rhi_clip;
  logic              win_empty;

  assign accept  = start && !busy;
  assign tier_ok = 32'(in_item.tier) < TIERS;

  // bin size of zero acts as one, the smoothing term is the larger of sigma and bin size
  always_comb begin
    bw_c = (binw_r == '0) ? CRD_W'(1) : binw_r;
    bh_c = (binh_r == '0) ? CRD_W'(1) : binh_r;
    sx_c = (smooth_r > bw_c) ? smooth_r : bw_c;
    sy_c = (smooth_r > bh_c) ? smooth_r : bh_c;
  end

  // divider operand select per setup step
  always_comb begin
    div_num = '0;
    div_den = DIV_DW'({bw_r, 1'b0});
    case (step_r)
      DS_AMP: begin
        div_num = {36'({wh_r, 3'b000}) + 36'(wh_r), 16'h0000};
        div_den = {rxy_r, 2'b00};
      end
      DS_CLO: begin
        div_num = (18'(x2_r) <= rx2_r) ? '0 : DIV_NW'(18'(x2_r) - rx2_r);
        div_den = DIV_DW'({bw_r, 1'b0});
      end
      DS_CHI: begin
        div_num = DIV_NW'(19'(x2_r) + 19'(rx2_r));
        div_den = DIV_DW'({bw_r, 1'b0});
      end
      DS_RLO: begin
        div_num = (18'(y2_r) <= ry2_r) ? '0 : DIV_NW'(18'(y2_r) - ry2_r);
        div_den = DIV_DW'({bh_r, 1'b0});
      end
      DS_RHI: begin
        div_num = DIV_NW'(19'(y2_r) + 19'(ry2_r));
        div_den = DIV_DW'({bh_r, 1'b0});
      end
      default: begin
        div_num = '0;
      end
    endcase
  end

  bkd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // clip the window to the grid
  always_comb begin
    chi_clip  = (chi_r > DIV_QB'(GRID - 1)) ? IDX_W'(GRID - 1) : IDX_W'(chi_r);
    rhi_clip  = (rhi_r > DIV_QB'(GRID - 1)) ? IDX_W'(GRID - 1) : IDX_W'(rhi_r);
    win_empty = (clo_r > DIV_QB'(chi_clip)) || (rlo_r > DIV_QB'(rhi_clip));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          case (in_item.req_type)
            REQ_ADD:                state_nxt = tier_ok ? F_SETUP : F_IDLE;
            REQ_CLEAR, REQ_READ:    state_nxt = F_PUSH;
            default:                state_nxt = F_IDLE;
          endcase
        end
      end
      F_SETUP: state_nxt = F_MUL;
      F_MUL:   state_nxt = F_DIV;
      F_DIV: begin
        if (div_done && step_r == DS_RHI) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full || !keep) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != F_IDLE) || hold;
    div_start = (state_r == F_DIV) && !launched_r;
    q_job     = '0;
    keep      = 1'b1;
    case (item_r.req_type)
      REQ_CLEAR: begin
        q_job.op = JOB_CLEAR;
      end
      REQ_READ: begin
        q_job.op   = JOB_READ;
        q_job.tier = item_r.tier;
        q_job.ok   = (32'(item_r.tier) < TIERS) && (32'(item_r.read_row) < GRID)
                     && (32'(item_r.read_col) < GRID);
        q_job.r0   = IDX_W'(item_r.read_row);
        q_job.c0   = IDX_W'(item_r.read_col);
      end
      default: begin
        q_job.op   = JOB_ADD;
        q_job.tier = item_r.tier;
        q_job.r0   = IDX_W'(rlo_r);
        q_job.r1   = rhi_clip;
        q_job.c0   = IDX_W'(clo_r);
        q_job.c1   = chi_clip;
        q_job.x2   = x2_r;
        q_job.y2   = y2_r;
        q_job.rx2  = rx2_r;
        q_job.ry2  = ry2_r;
        q_job.rxx  = rxx_r;
        q_job.ryy  = ryy_r;
        q_job.bw   = bw_r;
        q_job.bh   = bh_r;
        q_job.amp  = AMP_W'(amp_r);
        keep       = !win_empty;
      end
    endcase
    q_push = (state_r == F_PUSH) && !q_full && keep;
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      launched_r <= 1'b0;
      step_r     <= DS_AMP;
      smooth_r   <= '0;
      binw_r     <= CRD_W'(16);
      binh_r     <= CRD_W'(16);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SMOOTH: smooth_r <= cfg_data;
          CFG_BIN_W:  binw_r   <= cfg_data;
          CFG_BIN_H:  binh_r   <= cfg_data;
          default:    ;
        endcase
      end
      if (state_r == F_MUL) begin
        step_r     <= DS_AMP;
        launched_r <= 1'b0;
      end else if (state_r == F_DIV) begin
        if (div_start) begin
          launched_r <= 1'b1;
        end
        if (div_done) begin
          launched_r <= 1'b0;
          case (step_r)
            DS_AMP:  step_r <= DS_CLO;
            DS_CLO:  step_r <= DS_CHI;
            DS_CHI:  step_r <= DS_RLO;
            DS_RLO:  step_r <= DS_RHI;
            default: step_r <= DS_AMP;
          endcase
        end
      end
    end
  end

  // setup datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (state_r == F_SETUP) begin
      bw_r  <= bw_c;
      bh_r  <= bh_c;
      x2_r  <= {item_r.center_x, 1'b0};
      y2_r  <= {item_r.center_y, 1'b0};
      rx2_r <= RAD_W'(item_r.mod_width) + {1'b0, sx_c, 1'b0};
      ry2_r <= RAD_W'(item_r.mod_height) + {1'b0, sy_c, 1'b0};
    end
    if (state_r == F_MUL) begin
      wh_r  <= item_r.mod_width * item_r.mod_height;
      rxy_r <= rx2_r * ry2_r;
      rxx_r <= rx2_r * rx2_r;
      ryy_r <= ry2_r * ry2_r;
    end
    if (state_r == F_DIV && div_done) begin
      case (step_r)
        DS_AMP:  amp_r <= div_quo;
        DS_CLO:  clo_r <= div_quo;
        DS_CHI:  chi_r <= div_quo;
        DS_RLO:  rlo_r <= div_quo;
        default: rhi_r <= div_quo;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/bkd_back.sv =====
// back end: bin walk with read-modify-write, clearing sweep, bin read
// depends on bkd_pkg, bkd_div and bkd_ram; takes requests from the queue
`default_nettype none

module bkd_back import bkd_pkg::*; #(
  parameter int GRID  = 64,
  parameter int TIERS = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire job_t q_head,
  output logic      q_pop,
  output logic      hold,
  output logic      out_strobe,
  output out_item_t out_result
);

  localparam int IW    = $clog2(GRID);
  localparam int DEPTH = TIERS * GRID * GRID;
  localparam int AW    = $clog2(DEPTH);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic        init_r, axis_r;
  logic [AW-1:0]     clr_r;
  logic [IW-1:0]     r_r, c_r;
  logic [CEN_W-1:0]  cen_r, dist_r;
  logic [RR_W-1:0]   dsq_r;
  logic [PHI_W-1:0]  phi_r;
  logic [APY_W-1:0]  apy_r;
  logic [PROD_W-1:0] prod_r;
  logic              strobe_r;
  out_item_t         out_r;

  logic [POS2_W-1:0] pos;
  logic [RAD_W-1:0]  rad;
  logic [RR_W-1:0]   rr;
  logic [CRD_W-1:0]  stp;
  logic [IW-1:0]     idx;
  logic [CEN_W-1:0]  pos_w;
  logic [AW-1:0]     bin_a, read_a;
  logic              last_col, last_row;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [MEM_W-1:0]  wdata, rdata;
  logic [DEN_W:0]    sum;
  logic              sat;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_QB-1:0] div_quo;

  function automatic logic [AW-1:0] bin_addr(input logic [1:0] t, input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
    bin_addr = AW'(int'(t) * GRID * GRID + int'(r) * GRID + int'(c));
  endfunction

  // row or column operands of the bell evaluation
  always_comb begin
    pos   = axis_r ? job_r.y2  : job_r.x2;
    rad   = axis_r ? job_r.ry2 : job_r.rx2;
    rr    = axis_r ? job_r.ryy : job_r.rxx;
    stp   = axis_r ? job_r.bh  : job_r.bw;
    idx   = axis_r ? r_r       : c_r;
    pos_w = CEN_W'(pos);
    bin_a  = bin_addr(job_r.tier, r_r, c_r);
    read_a = bin_addr(job_r.tier, job_r.r0[IW-1:0], job_r.c0[IW-1:0]);
    last_col = c_r == job_r.c1[IW-1:0];
    last_row = r_r == job_r.r1[IW-1:0];
  end

  // saturating accumulate
  always_comb begin
    sum = {1'b0, rdata[DEN_W-1:0]} + (DEN_W + 1)'(prod_r[PROD_W-1:32]);
    sat = sum > {1'b0, DMAX};
  end

  assign div_num = {rr - dsq_r, 16'h0000};
  assign div_den = DIV_DW'(rr);

  bkd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  bkd_ram #(
    .W (MEM_W),
    .D (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          unique case (q_head.op)
            JOB_CLEAR: state_nxt = B_CLR;
            JOB_READ:  state_nxt = B_RQ;
            JOB_ADD:   state_nxt = B_CX;
            default:   state_nxt = B_IDLE;
          endcase
        end
      end
      B_CLR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_RQ: state_nxt = B_RS;
      B_RS: state_nxt = B_IDLE;
      B_CX: state_nxt = B_DX;
      B_DX: state_nxt = B_SQ;
      B_SQ: state_nxt = (dist_r >= CEN_W'(rad)) ? B_PM : B_DS;
      B_DS: state_nxt = B_DV;
      B_DV: begin
        if (div_done) begin
          state_nxt = B_PM;
        end
      end
      B_PM: state_nxt = axis_r ? B_CX : B_RD;
      B_RD: state_nxt = (last_col && last_row) ? B_IDLE : B_CX;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = (state_r == B_IDLE) && !q_empty;
    hold      = init_r;
    div_start = state_r == B_DS;
    we        = 1'b0;
    waddr     = bin_a;
    wdata     = {rdata[DEN_W] | sat, sat ? DMAX : sum[DEN_W-1:0]};
    re        = 1'b0;
    raddr     = bin_a;
    unique case (state_r)
      B_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
      end
      B_RQ: begin
        re    = job_r.ok;
        raddr = read_a;
      end
      B_PM: begin
        re = !axis_r;
      end
      B_RD: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_CLR;
      init_r   <= 1'b1;
      clr_r    <= '0;
      strobe_r <= 1'b0;
      axis_r   <= 1'b1;
      r_r      <= '0;
      c_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= state_r == B_RS;
      case (state_r)
        B_IDLE: begin
          clr_r  <= '0;
          axis_r <= 1'b1;
          r_r    <= q_head.r0[IW-1:0];
        end
        B_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH - 1)) begin
            init_r <= 1'b0;
          end
        end
        B_PM: begin
          if (axis_r) begin
            axis_r <= 1'b0;
            c_r    <= job_r.c0[IW-1:0];
          end
        end
        B_RD: begin
          if (last_col) begin
            axis_r <= 1'b1;
            r_r    <= r_r + 1'b1;
          end else begin
            c_r <= c_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    case (state_r)
      B_CX: cen_r  <= CEN_W'({idx, 1'b1}) * CEN_W'(stp);
      B_DX: dist_r <= (pos_w > cen_r) ? pos_w - cen_r : cen_r - pos_w;
      B_SQ: begin
        if (dist_r >= CEN_W'(rad)) begin
          phi_r <= '0;
        end else begin
          dsq_r <= dist_r[RAD_W-1:0] * dist_r[RAD_W-1:0];
        end
      end
      B_DV: begin
        if (div_done) begin
          phi_r <= div_quo[PHI_W-1:0];
        end
      end
      B_PM: begin
        if (axis_r) begin
          apy_r <= job_r.amp * phi_r;
        end else begin
          prod_r <= apy_r * phi_r;
        end
      end
      B_RS: begin
        out_r.bin_density <= job_r.ok ? rdata[DEN_W-1:0] : '0;
        out_r.saturated   <= job_r.ok ? rdata[DEN_W] : 1'b0;
      end
      default: ;
    endcase
  end

  assign out_strobe = strobe_r;
  assign out_result = out_r;

  a_strobe_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(state_r == B_RS))
    else $error("result strobe without a bin read");
  a_init_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> (state_r == B_CLR))
    else $error("request taken before the clearing pass ended");

endmodule

`default_nettype wire

// ===== src/bell_kernel_density_splat.sv =====
// top level of the bell kernel density splat block
// depends on bkd_pkg, bkd_front, bkd_queue and bkd_back
`default_nettype none

// Keeps TIERS grids of GRID x GRID saturating q8.16 bin densities. A request is
// taken when start is high and busy low; only a read gives a result, shown for
// one cycle with out_strobe, and the receiver cannot stall it. After reset, and
// for every clear request, the back end sweeps all TIERS*GRID*GRID bins of the
// store (16384 at the defaults) one bin per cycle; busy stays high through the
// sweep after reset. An add request keeps the front end busy through a setup
// step, a multiply step, five 18-step divisions for amplitude and window, and a
// step to queue the request, which waits while the queue is full. The back end
// then handles each bin of the window: centre, distance and square, a division
// for the column bell, and a read-modify-write of the bin memory that reads in
// state B_PM and writes in B_RD. Each row first evaluates its row bell the same
// way. A column or row outside the kernel radius skips its division. A read
// passes through the states B_RQ and B_RS after the back end takes it from the
// queue, and its result is registered out of B_RS. A two-entry queue lets the
// front end take and prepare the next request while the back end still walks
// the previous module.
module bell_kernel_density_splat import bkd_pkg::*; #(
  parameter int GRID  = 64,
  parameter int TIERS = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         in_item,
  output logic                  out_strobe,
  output out_item_t             out_result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CRD_W-1:0] cfg_data
);

  logic q_push, q_full, q_pop, q_empty, hold;
  job_t q_job, q_head;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  bkd_front #(
    .GRID  (GRID),
    .TIERS (TIERS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .hold      (hold),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  bkd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  bkd_back #(
    .GRID  (GRID),
    .TIERS (TIERS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .hold       (hold),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
